// ===== design/jpeg_coefficient_decode_core_macros.svh =====
// Assertion macros used by the checker file of the coefficient decoder.
`ifndef JPEG_COEFFICIENT_DECODE_CORE_MACROS_SVH
`define JPEG_COEFFICIENT_DECODE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define JCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jcd assertion failed");

// Next-cycle implication, disabled while reset is held.
`define JCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jcd assertion failed");

`endif

// ===== design/jcd_pkg.sv =====
// Shared types, constants and functions of the JPEG coefficient decoder.
package jcd_pkg;

  localparam int BLOCK_COEFFS     = 64;
  localparam int QUANT_TABLES_DEF = 4;
  localparam int COMPONENTS_DEF   = 4;
  localparam int POS_W            = 6;
  localparam int NPOS_W           = 7;
  localparam int IN_TDATA_W       = 48;
  localparam int OUT_TDATA_W      = 24;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_DC   = 2'd1;
  localparam logic [1:0] KIND_AC   = 2'd2;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_COEFFS - 1);

  // One decoded symbol on its way to the scaling stage.
  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic signed [15:0] value;
    logic               last;
    logic               overrun;
    logic               zero_step;
  } sym_t;

  // Quantization store access for one transaction; selects are {table, position}.
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [7:0] wr_sel;
    logic [7:0] rd_sel;
    logic [7:0] wr_data;
  } ram_req_t;

  // Decodes the JPEG magnitude bits of the given size; a clear top bit gives a negative value.
  function automatic logic signed [15:0] decode_magnitude(input logic [3:0] size,
                                                          input logic [14:0] raw);
    logic [15:0] mask;
    logic [15:0] bits;
    mask = (16'd1 << size) - 16'd1;
    bits = {1'b0, raw} & mask;
    if (size == 4'd0) begin
      decode_magnitude = 16'sd0;
    end else if (bits[size - 4'd1]) begin
      decode_magnitude = $signed(bits);
    end else begin
      decode_magnitude = $signed(bits - mask);
    end
  endfunction

endpackage

// ===== design/jcd_quant_ram.sv =====
// Quantization table store with one write and one registered read port.
module jcd_quant_ram import jcd_pkg::*; #(
  parameter int QUANT_TABLES = QUANT_TABLES_DEF
) (
  input  logic     clk,
  input  ram_req_t req,
  output logic [7:0] rdata
);

  localparam int DEPTH  = QUANT_TABLES * BLOCK_COEFFS;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[ADDR_W'(req.wr_sel)] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata_r <= mem[ADDR_W'(req.rd_sel)];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/jcd_symbol_stage.sv =====
// Symbol decode: block position tracking, DC prediction and store addressing.
module jcd_symbol_stage import jcd_pkg::*; #(
  parameter int QUANT_TABLES = QUANT_TABLES_DEF,
  parameter int COMPONENTS   = COMPONENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            in_tuser,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  s2_ready,
  output logic                  s1_valid,
  output sym_t                  s1_sym,
  output ram_req_t              ram_req
);

  localparam int CMP_AW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;

  logic              s1_valid_r, s1_valid_nxt;
  sym_t              s1_r, s1_nxt;
  logic [NPOS_W-1:0] npos_r, npos_nxt;
  logic [1:0]        act_r, act_nxt;
  logic [15:0]       pred_r [COMPONENTS];

  logic               fire;
  logic [1:0]         kind;
  logic [1:0]         table_select;
  logic [1:0]         component;
  logic [7:0]         run_size;
  logic [14:0]        extra_bits;
  logic [5:0]         quant_index;
  logic [7:0]         quant_value;
  logic signed [15:0] mag;
  logic               comp_ok;
  logic               sel_tbl_ok;
  logic               act_tbl_ok;
  logic [15:0]        pred_rd;
  logic [15:0]        dc_sum;
  logic [NPOS_W-1:0]  ac_pos;
  logic               pred_we;

  assign kind         = in_tuser;
  assign table_select = in_tdata[1:0];
  assign component    = in_tdata[3:2];
  assign run_size     = in_tdata[11:4];
  assign extra_bits   = in_tdata[26:12];
  assign quant_index  = in_tdata[32:27];
  assign quant_value  = in_tdata[40:33];

  assign in_tready = !s1_valid_r || s2_ready;
  assign fire      = in_tvalid && in_tready;

  assign mag        = decode_magnitude(run_size[3:0], extra_bits);
  assign comp_ok    = 32'(component) < COMPONENTS;
  assign sel_tbl_ok = 32'(table_select) < QUANT_TABLES;
  assign act_tbl_ok = 32'(act_r) < QUANT_TABLES;
  assign pred_rd    = comp_ok ? pred_r[CMP_AW'(component)] : 16'd0;
  assign dc_sum     = pred_rd + mag;
  assign ac_pos     = npos_r + NPOS_W'(run_size[7:4]);

  always_comb begin
    s1_nxt          = s1_r;
    s1_valid_nxt    = s1_valid_r && !s2_ready;
    npos_nxt        = npos_r;
    act_nxt         = act_r;
    pred_we         = 1'b0;
    ram_req.wr_en   = 1'b0;
    ram_req.rd_en   = fire;
    ram_req.wr_sel  = {table_select, quant_index};
    ram_req.rd_sel  = {act_r, 6'd0};
    ram_req.wr_data = quant_value;
    if (fire) begin
      s1_nxt.pos       = '0;
      s1_nxt.value     = 16'sd0;
      s1_nxt.last      = 1'b0;
      s1_nxt.overrun   = 1'b0;
      s1_nxt.zero_step = 1'b1;
      case (kind)
        KIND_LOAD: begin
          ram_req.wr_en = sel_tbl_ok;
        end
        KIND_DC: begin
          s1_valid_nxt     = 1'b1;
          s1_nxt.value     = $signed(dc_sum);
          s1_nxt.zero_step = !sel_tbl_ok || (dc_sum == 16'd0);
          ram_req.rd_sel   = {table_select, 6'd0};
          pred_we          = comp_ok;
          npos_nxt         = NPOS_W'(1);
          act_nxt          = table_select;
        end
        KIND_AC: begin
          if (npos_r != '0) begin
            s1_valid_nxt = 1'b1;
            if (run_size == 8'd0) begin
              // End of block: a zero at the next position closes it.
              s1_nxt.pos  = npos_r[POS_W-1:0];
              s1_nxt.last = 1'b1;
              npos_nxt    = '0;
            end else if (ac_pos > NPOS_W'(BLOCK_COEFFS - 1)) begin
              s1_nxt.pos     = LAST_POS;
              s1_nxt.last    = 1'b1;
              s1_nxt.overrun = 1'b1;
              npos_nxt       = '0;
            end else begin
              s1_nxt.pos       = ac_pos[POS_W-1:0];
              s1_nxt.value     = mag;
              s1_nxt.zero_step = !act_tbl_ok || (mag == 16'sd0);
              ram_req.rd_sel   = {act_r, ac_pos[POS_W-1:0]};
              if (ac_pos[POS_W-1:0] == LAST_POS) begin
                s1_nxt.last = 1'b1;
                npos_nxt    = '0;
              end else begin
                npos_nxt = ac_pos + NPOS_W'(1);
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      npos_r     <= '0;
      act_r      <= '0;
      for (int i = 0; i < COMPONENTS; i++) begin
        pred_r[i] <= '0;
      end
    end else begin
      s1_valid_r <= s1_valid_nxt;
      npos_r     <= npos_nxt;
      act_r      <= act_nxt;
      if (pred_we) begin
        pred_r[CMP_AW'(component)] <= dc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  assign s1_valid = s1_valid_r;
  assign s1_sym   = s1_r;

endmodule

// ===== design/jcd_scale_stage.sv =====
// Dequantizing multiply, 16-bit saturation and the result register.
module jcd_scale_stage import jcd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s1_valid,
  input  sym_t                   s1_sym,
  input  logic [7:0]             rdata,
  output logic                   s2_ready,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tuser
);

  logic               out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]   pos_r;
  logic signed [15:0] val_r, val_nxt;
  logic               last_r;
  logic               over_r;
  logic [7:0]         step;
  logic signed [24:0] prod;

  assign s2_ready = !out_valid_r || out_tready;

  // A forced zero step keeps unread or out-of-range entries out of the product.
  assign step = s1_sym.zero_step ? 8'd0 : rdata;
  assign prod = s1_sym.value * $signed({1'b0, step});

  always_comb begin
    if (prod > 25'sd32767) begin
      val_nxt = 16'sd32767;
    end else if (prod < -25'sd32768) begin
      val_nxt = -16'sd32768;
    end else begin
      val_nxt = prod[15:0];
    end
    out_valid_nxt = s2_ready ? s1_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      pos_r  <= s1_sym.pos;
      val_r  <= val_nxt;
      last_r <= s1_sym.last;
      over_r <= s1_sym.overrun;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, val_r, pos_r};
  assign out_tlast  = last_r;
  assign out_tuser  = over_r;

endmodule

// ===== design/jpeg_coefficient_decode_core.sv =====
// Top level of the JPEG baseline coefficient decoder and dequantizer.
//
//   Channel | Group  | Carries
//   --------+--------+---------------------------------------------------
//   input   | in_*   | load, DC or AC symbol transactions
//   result  | out_*  | zigzag position, dequantized coefficient, last, overrun
//
// Each DC or AC symbol of an open block passes through symbol decode with the store read,
// then the multiply and saturation into the result register; one per cycle unless the result stalls.
// The quantization store's registered read port sets the first stage boundary.
// Reset clears the block state, DC predictors and valid flags; the store is not cleared.
// A stalled result holds in its register while a further transaction still enters.
module jpeg_coefficient_decode_core import jcd_pkg::*; #(
  parameter int QUANT_TABLES = QUANT_TABLES_DEF,
  parameter int COMPONENTS   = COMPONENTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] kind
  input  logic [1:0]             in_tuser,
  // [1:0] table_select, [3:2] component, [11:4] run_size, [26:12] extra_bits,
  // [32:27] quant_index, [40:33] quant_value, [47:41] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [5:0] position, [21:6] coeff_value, [23:22] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // [0] overrun
  output logic                   out_tuser
);

  logic     s1_valid;
  sym_t     s1_sym;
  ram_req_t ram_req;
  logic     s2_ready;
  logic [7:0] rdata;

  jcd_symbol_stage #(
    .QUANT_TABLES(QUANT_TABLES),
    .COMPONENTS  (COMPONENTS)
  ) u_sym (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser (in_tuser),
    .in_tdata (in_tdata),
    .s2_ready (s2_ready),
    .s1_valid (s1_valid),
    .s1_sym   (s1_sym),
    .ram_req  (ram_req)
  );

  jcd_quant_ram #(
    .QUANT_TABLES(QUANT_TABLES)
  ) u_ram (
    .clk  (clk),
    .req  (ram_req),
    .rdata(rdata)
  );

  jcd_scale_stage u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_sym    (s1_sym),
    .rdata     (rdata),
    .s2_ready  (s2_ready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

// ===== design/jcd_checker.sv =====
// Port-level checks of the coefficient decoder, bound to its top level.
`include "jpeg_coefficient_decode_core_macros.svh"

module jcd_checker import jcd_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   out_tuser
);

  logic [POS_W-1:0]         out_pos;
  logic                     over_out;
  logic                     end_zero;
  logic                     stalled;
  logic [OUT_TDATA_W+1:0]   out_bus;

  assign out_pos  = out_tdata[POS_W-1:0];
  assign over_out = out_tvalid && out_tuser;
  assign end_zero = (out_pos == LAST_POS) && (out_tdata[21:6] == 16'd0);
  assign stalled  = out_tvalid && !out_tready;
  assign out_bus  = {out_tuser, out_tlast, out_tdata};

  // A dropped run always closes the block at the final position with a zero.
  `JCD_ASSERT_IMP(a_overrun_closes, clk, rst_n, over_out, out_tlast)
  `JCD_ASSERT_IMP(a_overrun_payload, clk, rst_n, over_out, end_zero)
  // The DC coefficient opens a block and so never ends it.
  `JCD_ASSERT_IMP(a_dc_not_last, clk, rst_n, out_tvalid && (out_pos == '0), !out_tlast)
  `JCD_ASSERT_NXT(a_out_hold, clk, rst_n, stalled, out_tvalid && $stable(out_bus))

endmodule

bind jpeg_coefficient_decode_core jcd_checker u_jcd_checker (.*);
